>>> rtl/npm_pkg.sv
// shared types and constants of the named position mark table
package npm_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned NameW   = 8;
  localparam int unsigned LineW   = 20;
  localparam int unsigned ColumnW = 12;

  // operation codes
  localparam logic [FuncW-1:0] FUNC_SET_NAMED = 3'd0;
  localparam logic [FuncW-1:0] FUNC_SET_CTX   = 3'd1;
  localparam logic [FuncW-1:0] FUNC_LOOKUP    = 3'd2;
  localparam logic [FuncW-1:0] FUNC_CLR_ALL   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_CLR_LINE  = 3'd4;

  // names that select the context mark
  localparam logic [NameW-1:0] CTX_NAME_QUOTE    = 8'h27;
  localparam logic [NameW-1:0] CTX_NAME_BACKTICK = 8'h60;

  // letter ranges
  localparam logic [NameW-1:0] UPPER_FIRST = 8'h41;
  localparam logic [NameW-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [NameW-1:0] LOWER_FIRST = 8'h61;
  localparam logic [NameW-1:0] LOWER_LAST  = 8'h7A;

  localparam logic [NameW-1:0] NAME_FREE = 8'h00;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // take the input word
    logic compare;  // register the match vectors
    logic commit;   // apply the update and load the result
  } npm_cmd_t;

endpackage

>>> rtl/npm_ctrl.sv
// controller of the named position mark table: sequencing and handshakes
module npm_ctrl
  import npm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output npm_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COMPARE = 2'd1;
  localparam logic [1:0] ST_COMMIT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the word
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.compare = (state_q == ST_COMPARE);
    cmd_o.commit  = (state_q == ST_COMMIT) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/npm_datapath.sv
// datapath of the named position mark table: slots, context mark, result word
module npm_datapath
  import npm_pkg::*;
#(
  parameter int unsigned MARK_SLOTS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  npm_cmd_t           cmd_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [NameW-1:0]   mark_name_i,
  input  logic [LineW-1:0]   line_ref_i,
  input  logic [ColumnW-1:0] column_pos_i,
  output logic               ok_o,
  output logic [LineW-1:0]   found_line_o,
  output logic [ColumnW-1:0] found_column_o
);

  // captured input word
  logic [FuncW-1:0]   func_q;
  logic [NameW-1:0]   name_q;
  logic [LineW-1:0]   line_q;
  logic [ColumnW-1:0] col_q;

  // slot storage
  logic [NameW-1:0]   names_q [MARK_SLOTS];
  logic [LineW-1:0]   lines_q [MARK_SLOTS];
  logic [ColumnW-1:0] cols_q  [MARK_SLOTS];
  logic [LineW-1:0]   ctx_line_q;
  logic [ColumnW-1:0] ctx_col_q;
  logic               ctx_valid_q;

  // compare stage
  logic [MARK_SLOTS-1:0] name_hit, free_slot, line_hit;
  logic [MARK_SLOTS-1:0] hit_oh_q, free_oh_q, line_hit_q;
  logic                  any_hit_q, any_free_q;
  logic                  is_letter_q, is_ctx_q, ctx_line_match_q;

  // commit stage
  logic [MARK_SLOTS-1:0] wr_slot, clr_slot;
  logic                  wr_name, clr_all, ctx_wr, ctx_clr;
  logic                  ok_d;
  logic [LineW-1:0]      fl_d, hit_line;
  logic [ColumnW-1:0]    fc_d, hit_col;
  logic                  ok_q;
  logic [LineW-1:0]      fl_q;
  logic [ColumnW-1:0]    fc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      name_q <= mark_name_i;
      line_q <= line_ref_i;
      col_q  <= column_pos_i;
    end
  end

  always_comb begin
    for (int i = 0; i < MARK_SLOTS; i++) begin
      free_slot[i] = (names_q[i] == NAME_FREE);
      name_hit[i]  = (names_q[i] == name_q) && (name_q != NAME_FREE);
      line_hit[i]  = !free_slot[i] && (lines_q[i] == line_q);
    end
  end

  // lowest set bit isolated, so the commit stage sees one slot only
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      hit_oh_q         <= name_hit & (~name_hit + MARK_SLOTS'(1));
      free_oh_q        <= free_slot & (~free_slot + MARK_SLOTS'(1));
      any_hit_q        <= |name_hit;
      any_free_q       <= |free_slot;
      line_hit_q       <= line_hit;
      ctx_line_match_q <= (ctx_line_q == line_q);
      is_letter_q      <= ((name_q >= UPPER_FIRST) && (name_q <= UPPER_LAST)) ||
                          ((name_q >= LOWER_FIRST) && (name_q <= LOWER_LAST));
      is_ctx_q         <= (name_q == CTX_NAME_QUOTE) || (name_q == CTX_NAME_BACKTICK);
    end
  end

  // and-or select of the matching slot's position
  always_comb begin
    hit_line = '0;
    hit_col  = '0;
    for (int i = 0; i < MARK_SLOTS; i++) begin
      hit_line = hit_line | ({LineW{hit_oh_q[i]}} & lines_q[i]);
      hit_col  = hit_col | ({ColumnW{hit_oh_q[i]}} & cols_q[i]);
    end
  end

  always_comb begin
    wr_slot  = '0;
    clr_slot = '0;
    wr_name  = 1'b0;
    clr_all  = 1'b0;
    ctx_wr   = 1'b0;
    ctx_clr  = 1'b0;
    ok_d     = 1'b0;
    fl_d     = '0;
    fc_d     = '0;
    unique case (func_q)
      FUNC_SET_NAMED: begin
        if (is_letter_q) begin
          priority if (any_hit_q) begin
            wr_slot = hit_oh_q;
            ok_d    = 1'b1;
          end else if (any_free_q) begin
            wr_slot = free_oh_q;
            wr_name = 1'b1;
            ok_d    = 1'b1;
          end else begin
            // table full: set refused
          end
        end
      end
      FUNC_SET_CTX: begin
        ctx_wr = 1'b1;
        ok_d   = 1'b1;
      end
      FUNC_LOOKUP: begin
        priority if (is_ctx_q) begin
          if (ctx_valid_q) begin
            ok_d = 1'b1;
            fl_d = ctx_line_q;
            fc_d = ctx_col_q;
          end
        end else if (any_hit_q) begin
          ok_d = 1'b1;
          fl_d = hit_line;
          fc_d = hit_col;
        end else begin
          // not found
        end
      end
      FUNC_CLR_ALL: begin
        clr_all = 1'b1;
        ctx_clr = 1'b1;
      end
      FUNC_CLR_LINE: begin
        clr_slot = line_hit_q;
        ctx_clr  = ctx_valid_q && ctx_line_match_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MARK_SLOTS; i++) begin
        names_q[i] <= NAME_FREE;
      end
      ctx_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < MARK_SLOTS; i++) begin
        if (clr_all || clr_slot[i]) begin
          names_q[i] <= NAME_FREE;
        end else if (wr_slot[i] && wr_name) begin
          names_q[i] <= name_q;
        end
      end
      if (ctx_wr) begin
        ctx_valid_q <= 1'b1;
      end else if (ctx_clr) begin
        ctx_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < MARK_SLOTS; i++) begin
        if (wr_slot[i]) begin
          lines_q[i] <= line_q;
          cols_q[i]  <= col_q;
        end
      end
      if (ctx_wr) begin
        ctx_line_q <= line_q;
        ctx_col_q  <= col_q;
      end
      ok_q <= ok_d;
      fl_q <= fl_d;
      fc_q <= fc_d;
    end
  end

  assign ok_o           = ok_q;
  assign found_line_o   = fl_q;
  assign found_column_o = fc_q;

endmodule

>>> rtl/named_position_mark_table_unit.sv
// named position mark table: set, look up and clear named and context marks
// steps: the accepted word is captured, its slots are compared, and then the
// result is committed; commit waits while the result register is blocked
// the controller works on one word at a time: a new word is stalled until the
// compare and commit steps of the previous word are done
// reset: every slot is freed and the context mark is invalid; positions are
// held in unreset registers and read only after they have been written
module named_position_mark_table_unit
  import npm_pkg::*;
#(
  parameter int unsigned MARK_SLOTS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FuncW-1:0]   func_i,
  input  logic [NameW-1:0]   mark_name_i,
  input  logic [LineW-1:0]   line_ref_i,
  input  logic [ColumnW-1:0] column_pos_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic [LineW-1:0]   found_line_o,
  output logic [ColumnW-1:0] found_column_o
);

  npm_cmd_t cmd;

  npm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  npm_datapath #(
    .MARK_SLOTS (MARK_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .mark_name_i    (mark_name_i),
    .line_ref_i     (line_ref_i),
    .column_pos_i   (column_pos_i),
    .ok_o           (ok_o),
    .found_line_o   (found_line_o),
    .found_column_o (found_column_o)
  );

endmodule
